// ===== hdl/pwlh_pkg.sv =====
`timescale 1ns / 1ps

package pwlh_pkg;

    // Field widths of the request and result items.
    localparam int XW       = 16;
    localparam int YW       = 16;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int REGION_W = 3;
    localparam int CFG_W    = 16;

    // Table capacity and register defaults.
    localparam int             DEF_MAX_POINTS = 64;
    localparam logic [YW-1:0]  DEF_EMPTY_Y    = 16'd11520;

    // Serial divider: a product of an X-wide and a Y-wide magnitude over an X-wide width.
    localparam int DVD_W     = 2 * YW;
    localparam int DVS_W     = XW;
    localparam int DIV_STEPS = DVD_W;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [REGION_W-1:0] {
        REGION_EMPTY    = 3'd0,
        REGION_LEFT     = 3'd1,
        REGION_RIGHT    = 3'd2,
        REGION_INTERP   = 3'd3,
        REGION_FALLBACK = 3'd4
    } t_region;

    typedef enum logic {
        CFG_POINT_COUNT = 1'b0,
        CFG_EMPTY_Y     = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } t_state;

    // One breakpoint as stored in the table.
    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } t_point;

endpackage

// ===== hdl/pwlh_req_if.sv =====
`timescale 1ns / 1ps

interface pwlh_req_if import pwlh_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [IDX_W-1:0]     point_index;
    logic signed [XW-1:0] point_x;
    logic [YW-1:0]        point_y;
    logic signed [XW-1:0] query_x;

    modport source (
        output valid, req_type, point_index, point_x, point_y, query_x,
        input  ready
    );

    modport sink (
        input  valid, req_type, point_index, point_x, point_y, query_x,
        output ready
    );
endinterface

// ===== hdl/pwlh_res_if.sv =====
`timescale 1ns / 1ps

interface pwlh_res_if import pwlh_pkg::*;;
    logic                valid;
    logic                ready;
    logic [YW-1:0]       ground_y;
    logic [REGION_W-1:0] region;

    modport source (
        output valid, ground_y, region,
        input  ready
    );

    modport sink (
        input  valid, ground_y, region,
        output ready
    );
endinterface

// ===== hdl/pwlh_table.sv =====
`timescale 1ns / 1ps

module pwlh_table import pwlh_pkg::*; #(
    parameter int DEPTH = DEF_MAX_POINTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_point        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_rdata
);

    t_point r_mem [DEPTH];
    t_point r_rdata;

    // Single write port; entries hold nothing meaningful until loaded.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read: the data follows the address in the next cycle.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pwlh_div.sv =====
`timescale 1ns / 1ps

module pwlh_div import pwlh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [YW-1:0]    o_quotient
);

    localparam int SW = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // Control: busy for one step per dividend bit, then a one-cycle done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + SW'(1);
                if (r_cnt == SW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in behind the dividend bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[YW-1:0];

endmodule

// ===== hdl/piecewise_linear_height_lookup.sv =====
`timescale 1ns / 1ps
// Channel    Direction  Handshake       Payload
// i_req      in         valid / ready   req_type, point_index, point_x, point_y, query_x
// o_res      out        valid / ready   ground_y, region
// i_cfg_*    in         write enable    i_cfg_idx, i_cfg_wdata
//
// A load produces nothing. For n breakpoints in use, a query makes two table reads
// for the end points, up to n - 1 reads in the segment scan (one table port, one
// entry a cycle), a multiply and a 32-step serial divide. Clamped and empty
// queries finish without the scan and the divide.
// Reset is synchronous and active low; the table itself is not cleared.
// A finished result waits in the output register while the next item is taken;
// a query only stalls at its end if the previous result has not been taken.

module piecewise_linear_height_lookup import pwlh_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    pwlh_req_if.sink          i_req,
    pwlh_res_if.source        o_res
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    // Configuration registers.
    logic [CNT_W-1:0] r_point_count;
    logic [YW-1:0]    r_empty_y;

    // Control.
    t_state r_state;
    t_state n_state;

    // Query context.
    logic signed [XW-1:0] r_qx;
    logic [NW-1:0]        r_n;
    logic [AW-1:0]        r_idx;
    logic [XW-1:0]        r_x0;
    logic [YW-1:0]        r_y0;
    logic [XW-1:0]        r_x1;
    logic [YW-1:0]        r_y1;
    logic [YW-1:0]        r_ylast;
    logic [DVD_W-1:0]     r_prod;
    logic [DVS_W-1:0]     r_w;
    logic                 r_neg;
    logic [YW-1:0]        r_res_y;
    t_region              r_res_region;

    // Output register.
    logic                 r_out_valid;
    logic [YW-1:0]        r_out_y;
    t_region              r_out_region;

    // Combinational helpers.
    logic                 in_fire;
    logic                 is_query;
    logic [NW-1:0]        n_used;
    logic                 tbl_we;
    logic [AW-1:0]        tbl_raddr;
    t_point               tbl_wdata;
    t_point               rd;
    logic                 in_ready;
    logic                 div_start;
    logic                 out_load;
    logic                 div_done;
    logic [YW-1:0]        div_quo;
    logic                 last_idx;
    logic                 seg_hit;
    logic                 left_hit;
    logic                 right_hit;
    logic signed [XW:0]   dx_full;
    logic signed [XW:0]   w_full;
    logic signed [YW:0]   dy_full;
    logic [YW-1:0]        dy_mag;

    assign in_fire  = i_req.valid && in_ready;
    assign is_query = (i_req.req_type == REQ_QUERY);

    // Breakpoints in use, limited to the table capacity.
    assign n_used = (32'(r_point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_point_count);

    // Loads beyond the table are dropped.
    assign tbl_we    = in_fire && !is_query && (32'(i_req.point_index) < MAX_POINTS);
    assign tbl_wdata = '{x: i_req.point_x, y: i_req.point_y};

    pwlh_table #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(i_req.point_index)),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (rd)
    );

    pwlh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_w),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Comparisons against the entry that the table returns this cycle.
    assign left_hit  = ($signed(r_qx) <= $signed(rd.x));
    assign right_hit = ($signed(r_qx) >= $signed(rd.x));
    assign seg_hit   = ($signed(r_qx) >= $signed(r_x0)) && ($signed(r_qx) <= $signed(rd.x));
    assign last_idx  = (r_idx == AW'(r_n - NW'(1)));

    // Segment arithmetic; the query lies inside the segment, so dx and w are non-negative.
    assign dx_full = {r_qx[XW-1], r_qx} - {r_x0[XW-1], r_x0};
    assign w_full  = {r_x1[XW-1], r_x1} - {r_x0[XW-1], r_x0};
    assign dy_full = {1'b0, r_y1} - {1'b0, r_y0};
    assign dy_mag  = dy_full[YW] ? YW'(-dy_full) : dy_full[YW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && is_query) begin
                    n_state = (n_used == '0) ? ST_DONE : ST_FIRST;
                end
            end
            ST_FIRST:  n_state = left_hit ? ST_DONE : ST_LAST;
            ST_LAST:   n_state = right_hit ? ST_DONE : ST_SCAN;
            ST_SCAN: begin
                if (seg_hit) begin
                    n_state = ST_MUL;
                end else if (last_idx) begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL:    n_state = (w_full == '0) ? ST_DONE : ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV;
            ST_DIV:    n_state = div_done ? ST_DONE : ST_DIV;
            ST_DONE:   n_state = out_load ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake, table read address, divider start, result load.
    always_comb begin
        in_ready  = 1'b0;
        tbl_raddr = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready  = 1'b1;
            ST_FIRST:  tbl_raddr = AW'(r_n - NW'(1));
            ST_LAST:   tbl_raddr = AW'(1);
            ST_SCAN:   tbl_raddr = r_idx + AW'(1);
            ST_MUL:    tbl_raddr = '0;
            ST_DIV_GO: div_start = 1'b1;
            ST_DIV:    tbl_raddr = '0;
            ST_DONE:   out_load  = !r_out_valid || o_res.ready;
            default:   in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_empty_y     <= DEF_EMPTY_Y;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POINT_COUNT: r_point_count <= i_cfg_wdata[CNT_W-1:0];
                CFG_EMPTY_Y:     r_empty_y     <= i_cfg_wdata[YW-1:0];
                default:         r_empty_y     <= r_empty_y;
            endcase
        end
    end

    // Query datapath, stepped by the state machine.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire && is_query) begin
                    r_qx         <= i_req.query_x;
                    r_n          <= n_used;
                    r_res_y      <= r_empty_y;
                    r_res_region <= REGION_EMPTY;
                end
            end
            ST_FIRST: begin
                r_x0         <= rd.x;
                r_y0         <= rd.y;
                r_res_y      <= rd.y;
                r_res_region <= REGION_LEFT;
            end
            ST_LAST: begin
                r_ylast      <= rd.y;
                r_idx        <= AW'(1);
                r_res_y      <= rd.y;
                r_res_region <= REGION_RIGHT;
            end
            ST_SCAN: begin
                if (seg_hit) begin
                    r_x1 <= rd.x;
                    r_y1 <= rd.y;
                end else begin
                    r_x0         <= rd.x;
                    r_y0         <= rd.y;
                    r_idx        <= r_idx + AW'(1);
                    r_res_y      <= r_ylast;
                    r_res_region <= REGION_FALLBACK;
                end
            end
            ST_MUL: begin
                r_prod       <= {{(DVD_W-XW){1'b0}}, dx_full[XW-1:0]}
                                * {{(DVD_W-YW){1'b0}}, dy_mag};
                r_w          <= w_full[XW-1:0];
                r_neg        <= dy_full[YW];
                r_res_y      <= r_y0;
                r_res_region <= REGION_INTERP;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_res_y <= r_neg ? (r_y0 - div_quo) : (r_y0 + div_quo);
                end
            end
            default: begin
                r_res_region <= r_res_region;
            end
        endcase
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_y      <= r_res_y;
            r_out_region <= r_res_region;
        end
    end

    assign i_req.ready    = in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.ground_y = r_out_y;
    assign o_res.region   = r_out_region;

endmodule

// ===== tb/piecewise_linear_height_lookup_tb.sv =====
`timescale 1ns / 1ps

module piecewise_linear_height_lookup_tb;
    import pwlh_pkg::*;

    localparam int MAX_PTS        = DEF_MAX_POINTS;
    localparam int DRAIN_CYCLES   = 128;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 550;

    // One request as the driver presents it.
    typedef struct {
        t_req                 kind;
        logic [IDX_W-1:0]     idx;
        logic signed [XW-1:0] px;
        logic [YW-1:0]        py;
        logic signed [XW-1:0] qx;
    } t_request;

    // One expected lookup result.
    typedef struct {
        logic [YW-1:0] ground_y;
        t_region       region;
    } t_height;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    pwlh_req_if req_if ();
    pwlh_res_if res_if ();

    piecewise_linear_height_lookup i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Predicted block state.
    logic signed [XW-1:0] tab_x [MAX_PTS];
    logic [YW-1:0]        tab_y [MAX_PTS];
    logic [CNT_W-1:0]     point_count = '0;
    logic [YW-1:0]        empty_height = DEF_EMPTY_Y;

    // Table as the stimulus has loaded it, used to aim queries.
    int plan_x [MAX_PTS];
    int plan_y [MAX_PTS];

    t_request request_queue [$];
    t_height  expected_heights [$];

    bit calm = 1'b0;
    int hold_requests = 0;
    int items_pushed = 0;
    int loads_taken = 0;
    int queries_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int setups = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    // Expected height and region for a query against the predicted table.
    function automatic t_height height_at(input logic signed [XW-1:0] qx);
        t_height h;
        int      n;
        int      q;
        int      x0;
        int      x1;
        longint  w;
        longint  v;
        bit      hit;
        n = (int'(point_count) > MAX_PTS) ? MAX_PTS : int'(point_count);
        q = int'(qx);
        hit = 1'b0;
        if (n == 0) begin
            h.ground_y = empty_height;
            h.region = REGION_EMPTY;
        end else if (q <= int'(tab_x[0])) begin
            h.ground_y = tab_y[0];
            h.region = REGION_LEFT;
        end else if (q >= int'(tab_x[n-1])) begin
            h.ground_y = tab_y[n-1];
            h.region = REGION_RIGHT;
        end else begin
            h.ground_y = tab_y[n-1];
            h.region = REGION_FALLBACK;
            for (int i = 0; i + 1 < n; i++) begin
                x0 = int'(tab_x[i]);
                x1 = int'(tab_x[i+1]);
                if (!hit && q >= x0 && q <= x1) begin
                    hit = 1'b1;
                    w = longint'(x1) - longint'(x0);
                    v = longint'(tab_y[i]);
                    // Quotient truncates toward zero, as SystemVerilog division does.
                    if (w > 0) begin
                        v += ((longint'(q) - longint'(x0))
                              * (longint'(tab_y[i+1]) - longint'(tab_y[i]))) / w;
                    end
                    if (v < 0) begin
                        v = 0;
                    end
                    if (v > 65535) begin
                        v = 65535;
                    end
                    h.ground_y = v[YW-1:0];
                    h.region = REGION_INTERP;
                end
            end
        end
        return h;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    task automatic push_load(input int idx, input int x, input int y);
        t_request it;
        it.kind = REQ_LOAD;
        it.idx = idx[IDX_W-1:0];
        it.px = x[XW-1:0];
        it.py = y[YW-1:0];
        it.qx = XW'($urandom_range(0, 65535));
        plan_x[idx] = x;
        plan_y[idx] = y;
        request_queue.push_back(it);
        items_pushed++;
    endtask

    task automatic push_query(input int q);
        t_request it;
        it.kind = REQ_QUERY;
        it.idx = IDX_W'($urandom_range(0, 63));
        it.px = XW'($urandom_range(0, 65535));
        it.py = YW'($urandom_range(0, 65535));
        it.qx = q[XW-1:0];
        request_queue.push_back(it);
        items_pushed++;
    endtask

    // Register write; the predictor follows at once since the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[CFG_W-1:0];
        if (idx == CFG_POINT_COUNT) begin
            point_count = value[CNT_W-1:0];
        end else begin
            empty_height = value[YW-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result is back, then let loads settle.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (request_queue.size() != 0 || req_if.valid || expected_heights.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Request driver; each accepted transfer updates the predicted table or queues a height.
    t_request cur_req;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.req_type <= REQ_LOAD;
            req_if.point_index <= '0;
            req_if.point_x <= '0;
            req_if.point_y <= '0;
            req_if.query_x <= '0;
            gap_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                if (cur_req.kind == REQ_LOAD) begin
                    tab_x[cur_req.idx] = cur_req.px;
                    tab_y[cur_req.idx] = cur_req.py;
                    loads_taken++;
                end else begin
                    expected_heights.push_back(height_at(cur_req.qx));
                    queries_taken++;
                end
                gap_left = pick_gap();
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    cur_req = request_queue.pop_front();
                    req_if.req_type <= cur_req.kind;
                    req_if.point_index <= cur_req.idx;
                    req_if.point_x <= cur_req.px;
                    req_if.point_y <= cur_req.py;
                    req_if.query_x <= cur_req.qx;
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure and an occasional long hold-off.
    t_height want;
    int      stall_left = 0;
    int      hold_left = 0;
    int      holds_served = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (expected_heights.size() == 0) begin
                    report_mismatch("unexpected result, ground_y",
                                    int'(res_if.ground_y), -1);
                end else begin
                    want = expected_heights.pop_front();
                    if (res_if.ground_y !== want.ground_y) begin
                        report_mismatch("ground_y", int'(res_if.ground_y),
                                        int'(want.ground_y));
                    end
                    if (res_if.region !== want.region) begin
                        report_mismatch("region", int'(res_if.region), int'(want.region));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Watchdog on cycles without any transfer or register write.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus: a directed opening, then random table setups with queries.
    initial begin
        int  probes [8];
        int  n;
        int  n_act;
        int  ops;
        int  k;
        int  q;
        int  d;
        int  span;
        int  xv;
        int  yv;
        int  r;
        int  phase;
        bit  ordered;

        probes = '{-32768, 32767, -32767, 0, 200, 201, 32766, -101};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: the reset height first, then both extremes of the register.
        push_query(291);
        push_query(-32768);
        wait_idle();
        write_reg(CFG_EMPTY_Y, 0);
        push_query(32767);
        wait_idle();
        write_reg(CFG_EMPTY_Y, 65535);
        push_query(0);

        // Five points over the full x range, with a repeated x inside.
        push_load(0, -32768, 65535);
        push_load(1, -100, 0);
        push_load(2, 200, 4000);
        push_load(3, 200, 1234);
        push_load(4, 32767, 65535);
        wait_idle();
        write_reg(CFG_POINT_COUNT, 5);
        setups++;
        foreach (probes[j]) begin
            push_query(probes[j]);
        end

        // A single point: everything clamps left or right.
        wait_idle();
        write_reg(CFG_POINT_COUNT, 1);
        setups++;
        push_query(-32768);
        push_query(-32767);

        // A table whose x values go down and then up.
        push_load(0, 100, 500);
        push_load(1, -50, 9000);
        push_load(2, 300, 20);
        wait_idle();
        write_reg(CFG_POINT_COUNT, 3);
        setups++;
        push_query(200);

        phase = 0;
        while (items_pushed < TARGET_ITEMS) begin
            wait_idle();
            phase++;
            if (phase == 2) begin
                n = MAX_PTS;
            end else if (phase == 5) begin
                n = 127;
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    n = 0;
                end else if (r == 1) begin
                    n = 1;
                end else if (r == 2) begin
                    n = $urandom_range(13, 40);
                end else begin
                    n = $urandom_range(2, 12);
                end
            end
            n_act = (n > MAX_PTS) ? MAX_PTS : n;
            ordered = ($urandom_range(0, 9) != 0);
            calm = 1'b0;

            // Load every entry that the new count brings into use.
            span = 65535 / ((n_act > 1) ? n_act - 1 : 1);
            xv = ($urandom_range(0, 3) == 0) ? -32768 : -32768 + int'($urandom_range(0, span));
            for (k = 0; k < n_act; k++) begin
                if (!ordered) begin
                    xv = int'($urandom_range(0, 65535)) - 32768;
                end
                r = $urandom_range(0, 7);
                yv = (r == 0) ? 0 : (r == 1) ? 65535 : int'($urandom_range(0, 65535));
                push_load(k, xv, yv);
                if (ordered) begin
                    xv += ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, span));
                    if (xv > 32767) begin
                        xv = 32767;
                    end
                end
            end
            wait_idle();
            write_reg(CFG_POINT_COUNT, n);
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 3);
                write_reg(CFG_EMPTY_Y, (r == 0) ? 0 : (r == 1) ? 65535
                                                        : int'($urandom_range(0, 65535)));
            end
            setups++;
            calm = ($urandom_range(0, 3) == 0);
            ops = $urandom_range(20, 40);

            // Hold the result side off so that the block backs up into its input.
            if (phase == 4) begin
                calm = 1'b1;
                ops = 40;
                hold_requests++;
            end

            for (int j = 0; j < ops; j++) begin
                k = (n_act > 0) ? $urandom_range(0, n_act - 1) : 0;
                if ($urandom_range(0, 99) < 85) begin
                    case ($urandom_range(0, 5))
                        0: q = int'($urandom_range(0, 65535)) - 32768;
                        1: q = plan_x[k];
                        2: q = plan_x[k] + int'($urandom_range(0, 4)) - 2;
                        3: q = (k + 1 < n_act) ? (plan_x[k] + plan_x[k+1]) / 2 : plan_x[k] - 1;
                        4: begin
                            if (k + 1 < n_act) begin
                                d = plan_x[k+1] - plan_x[k];
                                if (d < 0) begin
                                    d = -d;
                                end
                                q = plan_x[k] + int'($urandom_range(0, d));
                            end else begin
                                q = int'($urandom_range(0, 65535)) - 32768;
                            end
                        end
                        default: q = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
                    endcase
                    if (q < -32768) begin
                        q = -32768;
                    end
                    if (q > 32767) begin
                        q = 32767;
                    end
                    push_query(q);
                end else if (n_act > 0 && $urandom_range(0, 9) < 7) begin
                    // New height for an existing point; the x order stays.
                    push_load(k, plan_x[k], int'($urandom_range(0, 65535)));
                end else begin
                    push_load($urandom_range(0, 63), int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)));
                end
            end
        end

        wait_idle();
        $display("Covered %0d loads and %0d queries over %0d table setups,",
                 loads_taken, queries_taken, setups);
        $display("with %0d results checked and %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
